// File: rtl/act_pkg.sv
// ----------------------------------------------------------------------------
// act_pkg - shared constants for the tilt angle pipeline
// Word widths, the CORDIC angle table, the gain constant and the output
// formats used by the vectoring chain and the top level.
// ----------------------------------------------------------------------------
package act_pkg;

	// Number of micro-rotations requested and the length of the angle table.
	localparam int CORDIC_STEPS        = 16;
	localparam int ANGLE_FRACTION_BITS = 7;
	localparam int TBL_LEN             = 24;

	// Micro-rotations actually built: never more than the table holds.
	localparam int NSTEPS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;

	// Raw sample width and the operand grid (counts times 2^12).
	localparam int SAMPLE_W      = 16;
	localparam int OPERAND_SHIFT = 12;

	// One datapath width covers operands, magnitudes and angle accumulators.
	// The largest value is the pitch magnitude, about 2^29.2, and the largest
	// angle sum is about 3e9 (degrees with 24 fraction bits).
	localparam int DATA_W = 34;

	// Angle accumulator fraction bits and the shift to the output grid.
	localparam int ACC_FRAC  = 24;
	localparam int OUT_SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;

	// Output field widths.
	localparam int ROLL_W  = 16;
	localparam int PITCH_W = 15;

	// CORDIC gain 1.6467602581 in Q30, and the product width for -x times it.
	localparam int GAIN_W = 32;
	localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 32'sd1768195363;
	localparam int NEGX_W = SAMPLE_W + 1;
	localparam int PROD_W = NEGX_W + GAIN_W;

	// Rounding of the gain product: (p * 2^12 + 2^29) >> 30 == (p + 2^17) >> 18.
	localparam int GAIN_SHIFT = 30 - OPERAND_SHIFT;

	// Ninety degrees on the accumulator grid.
	localparam logic signed [DATA_W-1:0] DEG90_ACC = 34'sd1509949440;

	// Saturation limits on the output grid.
	localparam logic signed [DATA_W-1:0] ROLL_LIM  = DATA_W'(180 << ANGLE_FRACTION_BITS);
	localparam logic signed [DATA_W-1:0] PITCH_LIM = DATA_W'(90 << ANGLE_FRACTION_BITS);

	// atan(2^-i) in degrees with 24 fraction bits, rounded to nearest.
	localparam logic signed [DATA_W-1:0] ATAN_TBL [TBL_LEN] = '{
		34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
		34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
		34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
		34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
		34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
		34'sd917,       34'sd458,       34'sd229,       34'sd115
	};

endpackage

// File: rtl/act_cordic.sv
// ----------------------------------------------------------------------------
// act_cordic - pipelined CORDIC vectoring chain
// One register stage for the quadrant correction, then one register stage
// per micro-rotation. Returns atan2(y, x) in degrees (24 fraction bits) and
// the gain-scaled magnitude, and carries a side word along with each beat.
// ----------------------------------------------------------------------------
module act_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [act_pkg::DATA_W-1:0]  x_in,
	input  logic signed [act_pkg::DATA_W-1:0]  y_in,
	input  logic signed [act_pkg::DATA_W-1:0]  side_in,
	output logic                               out_valid,
	output logic signed [act_pkg::DATA_W-1:0]  mag_out,
	output logic signed [act_pkg::DATA_W-1:0]  ang_out,
	output logic signed [act_pkg::DATA_W-1:0]  side_out
);

	localparam int N = act_pkg::NSTEPS;

	// Stage k holds the vector after k micro-rotations; stage 0 is the
	// quadrant-corrected input.
	logic                              vld_sk  [N+1];
	logic                              zero_sk [N+1];
	logic signed [act_pkg::DATA_W-1:0] x_sk    [N+1];
	logic signed [act_pkg::DATA_W-1:0] y_sk    [N+1];
	logic signed [act_pkg::DATA_W-1:0] ang_sk  [N+1];
	logic signed [act_pkg::DATA_W-1:0] side_sk [N+1];

	// Quadrant correction: a vector in the left half plane is turned by
	// ninety degrees toward the right half plane.
	logic                              pre_zero;
	logic signed [act_pkg::DATA_W-1:0] pre_x;
	logic signed [act_pkg::DATA_W-1:0] pre_y;
	logic signed [act_pkg::DATA_W-1:0] pre_ang;

	always_comb begin
		pre_zero = (x_in == '0) && (y_in == '0);
		pre_x    = x_in;
		pre_y    = y_in;
		pre_ang  = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				pre_x   = y_in;
				pre_y   = -x_in;
				pre_ang = act_pkg::DEG90_ACC;
			end else begin
				pre_x   = -y_in;
				pre_y   = x_in;
				pre_ang = -act_pkg::DEG90_ACC;
			end
		end
	end

	// Valid bit of the correction stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else begin
			vld_sk[0] <= in_valid;
		end
	end

	// Payload of the correction stage.
	always_ff @(posedge clk) begin
		zero_sk[0] <= pre_zero;
		x_sk[0]    <= pre_x;
		y_sk[0]    <= pre_y;
		ang_sk[0]  <= pre_ang;
		side_sk[0] <= side_in;
	end

	// One micro-rotation per stage, turning the vector toward the x axis.
	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [act_pkg::DATA_W-1:0] dx;
		logic signed [act_pkg::DATA_W-1:0] dy;

		assign dx = y_sk[i] >>> i;
		assign dy = x_sk[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[i+1] <= 1'b0;
			end else begin
				vld_sk[i+1] <= vld_sk[i];
			end
		end

		always_ff @(posedge clk) begin
			zero_sk[i+1] <= zero_sk[i];
			side_sk[i+1] <= side_sk[i];
			if (y_sk[i] > 0) begin
				x_sk[i+1]   <= x_sk[i] + dx;
				y_sk[i+1]   <= y_sk[i] - dy;
				ang_sk[i+1] <= ang_sk[i] + act_pkg::ATAN_TBL[i];
			end else begin
				x_sk[i+1]   <= x_sk[i] - dx;
				y_sk[i+1]   <= y_sk[i] + dy;
				ang_sk[i+1] <= ang_sk[i] - act_pkg::ATAN_TBL[i];
			end
		end
	end

	// A zero vector has angle zero; its magnitude stays zero on its own.
	assign out_valid = vld_sk[N];
	assign mag_out   = x_sk[N];
	assign ang_out   = zero_sk[N] ? '0 : ang_sk[N];
	assign side_out  = side_sk[N];

endmodule

// File: rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles - roll and pitch from one accelerometer sample
// Roll = atan2(y, z) and pitch = atan2(-x, |(y, z)|) in degrees with seven
// fraction bits, from two chained CORDIC vectoring pipelines.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------------
//  sample    start / busy       accel_x, accel_y, accel_z (16 b signed)
//  result    done (strobe)      roll_angle (16 b), pitch_angle (15 b)
//
// A sample beat is taken at any edge where start is high; busy is always low,
// so a new sample can enter every cycle. Each beat passes through one gain
// multiply stage, two CORDIC chains of one correction stage plus one stage
// per micro-rotation, and one rounding stage. Reset clears only the valid bits.
// The result strobe cannot be held off, so the pipeline never stalls.
//
module accel_tilt_angles (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [act_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [act_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [act_pkg::SAMPLE_W-1:0] accel_z,
	output logic                                done,
	output logic signed [act_pkg::ROLL_W-1:0]   roll_angle,
	output logic signed [act_pkg::PITCH_W-1:0]  pitch_angle
);

	localparam int EXT_W = act_pkg::DATA_W - act_pkg::SAMPLE_W - act_pkg::OPERAND_SHIFT;

	// The pipeline always moves, so it is never busy.
	assign busy = 1'b0;

	// Stage 1: operands on the 2^12 grid and -x times the CORDIC gain.
	logic                                valid_s1;
	logic signed [act_pkg::DATA_W-1:0]   z_s1;
	logic signed [act_pkg::DATA_W-1:0]   y_s1;
	logic signed [act_pkg::PROD_W-1:0]   prod_s1;
	logic signed [act_pkg::NEGX_W-1:0]   negx;

	assign negx = -$signed({accel_x[act_pkg::SAMPLE_W-1], accel_x});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		z_s1    <= $signed({{EXT_W{accel_z[act_pkg::SAMPLE_W-1]}}, accel_z,
			{act_pkg::OPERAND_SHIFT{1'b0}}});
		y_s1    <= $signed({{EXT_W{accel_y[act_pkg::SAMPLE_W-1]}}, accel_y,
			{act_pkg::OPERAND_SHIFT{1'b0}}});
		prod_s1 <= act_pkg::PROD_W'(negx) * act_pkg::PROD_W'(act_pkg::GAIN_Q30);
	end

	// Round the gain product half up onto the operand grid.
	logic signed [act_pkg::PROD_W-1:0] nx_round;
	logic signed [act_pkg::DATA_W-1:0] nx_gain;

	assign nx_round = (prod_s1 + (act_pkg::PROD_W'(1) <<< (act_pkg::GAIN_SHIFT - 1)))
		>>> act_pkg::GAIN_SHIFT;
	assign nx_gain  = nx_round[act_pkg::DATA_W-1:0];

	// Roll chain: atan2(y, z); the gained -x rides along as the side word.
	logic                              roll_valid;
	logic signed [act_pkg::DATA_W-1:0] mag_yz;
	logic signed [act_pkg::DATA_W-1:0] roll_acc;
	logic signed [act_pkg::DATA_W-1:0] nx_dly;

	act_cordic u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.x_in      (z_s1),
		.y_in      (y_s1),
		.side_in   (nx_gain),
		.out_valid (roll_valid),
		.mag_out   (mag_yz),
		.ang_out   (roll_acc),
		.side_out  (nx_dly)
	);

	// Pitch chain: atan2(-x * gain, gain * |(y, z)|); roll rides along.
	logic                              pitch_valid;
	logic signed [act_pkg::DATA_W-1:0] pitch_mag;
	logic signed [act_pkg::DATA_W-1:0] pitch_acc;
	logic signed [act_pkg::DATA_W-1:0] roll_dly;

	act_cordic u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (roll_valid),
		.x_in      (mag_yz),
		.y_in      (nx_dly),
		.side_in   (roll_acc),
		.out_valid (pitch_valid),
		.mag_out   (pitch_mag),
		.ang_out   (pitch_acc),
		.side_out  (roll_dly)
	);

	// Final stage: round half up to the output grid and saturate.
	logic signed [act_pkg::DATA_W-1:0] roll_rnd;
	logic signed [act_pkg::DATA_W-1:0] pitch_rnd;
	logic signed [act_pkg::DATA_W-1:0] roll_sat;
	logic signed [act_pkg::DATA_W-1:0] pitch_sat;

	always_comb begin
		roll_rnd  = (roll_dly + (act_pkg::DATA_W'(1) <<< (act_pkg::OUT_SHIFT - 1)))
			>>> act_pkg::OUT_SHIFT;
		pitch_rnd = (pitch_acc + (act_pkg::DATA_W'(1) <<< (act_pkg::OUT_SHIFT - 1)))
			>>> act_pkg::OUT_SHIFT;

		roll_sat = roll_rnd;
		if (roll_rnd > act_pkg::ROLL_LIM) begin
			roll_sat = act_pkg::ROLL_LIM;
		end else if (roll_rnd < -act_pkg::ROLL_LIM) begin
			roll_sat = -act_pkg::ROLL_LIM;
		end

		pitch_sat = pitch_rnd;
		if (pitch_rnd > act_pkg::PITCH_LIM) begin
			pitch_sat = act_pkg::PITCH_LIM;
		end else if (pitch_rnd < -act_pkg::PITCH_LIM) begin
			pitch_sat = -act_pkg::PITCH_LIM;
		end
	end

	// The magnitude from the pitch chain is not part of the result; it ends
	// in a spare register that nothing reads.
	logic unused_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pitch_valid;
		end
	end

	always_ff @(posedge clk) begin
		roll_angle   <= roll_sat[act_pkg::ROLL_W-1:0];
		pitch_angle  <= pitch_sat[act_pkg::PITCH_W-1:0];
		unused_mag_q <= ^pitch_mag;
	end

endmodule

// File: sim/tb_accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles - self-checking testbench for the tilt angle pipeline
// Drives accelerometer samples through start/busy, predicts roll and pitch
// with a bit-exact CORDIC model of its own, and checks every done strobe
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles;

	// Pipeline depth of the block, used for the final drain.
	localparam int PIPE_LAT = 2 * act_pkg::CORDIC_STEPS + 4;

	// Predictor formats: operands on a 2^12 grid, angles in degrees with
	// 24 fraction bits, the gain in Q30.
	localparam int     ROT_LEN    = 24;
	localparam int     RND_SHIFT  = 24 - act_pkg::ANGLE_FRACTION_BITS;
	localparam longint COUNT_GRID = 4096;
	localparam longint GAIN_Q30   = 64'sd1768195363;
	localparam longint QUARTER    = 64'sd1509949440;
	localparam longint ROT_DEG [ROT_LEN] = '{
		64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
		64'sd60000934,  64'sd30029717,  64'sd15018523,  64'sd7509720,
		64'sd3754917,   64'sd1877466,   64'sd938734,    64'sd469367,
		64'sd234684,    64'sd117342,    64'sd58671,     64'sd29335,
		64'sd14668,     64'sd7334,      64'sd3667,      64'sd1833,
		64'sd917,       64'sd458,       64'sd229,       64'sd115
	};

	typedef struct packed {
		logic signed [act_pkg::ROLL_W-1:0]  roll;
		logic signed [act_pkg::PITCH_W-1:0] pitch;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [act_pkg::SAMPLE_W-1:0] accel_x;
	logic signed [act_pkg::SAMPLE_W-1:0] accel_y;
	logic signed [act_pkg::SAMPLE_W-1:0] accel_z;
	logic done;
	logic signed [act_pkg::ROLL_W-1:0]  roll_angle;
	logic signed [act_pkg::PITCH_W-1:0] pitch_angle;

	tilt_t pending_tilt [$];
	tilt_t want;
	int    err_count = 0;
	int    max_gap   = 4;

	accel_tilt_angles dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.done       (done),
		.roll_angle (roll_angle),
		.pitch_angle(pitch_angle)
	);

	// Free-running clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Vectoring CORDIC: angle of (xin, yin) in degrees with 24 fraction bits,
	// and the gained magnitude left in the x register.
	function automatic longint cordic_atan2(input longint xin, input longint yin,
			output longint mag);
		longint xv, yv, ang, dx, dy, t;
		xv  = xin;
		yv  = yin;
		ang = 0;
		mag = 0;
		if (xv == 0 && yv == 0)
			return 0;
		// Left half plane: turn by 90 degrees first.
		if (xv < 0) begin
			if (yv >= 0) begin
				t = xv; xv = yv; yv = -t; ang = QUARTER;
			end else begin
				t = xv; xv = -yv; yv = t; ang = -QUARTER;
			end
		end
		for (int i = 0; i < act_pkg::CORDIC_STEPS && i < ROT_LEN; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv += dx; yv -= dy; ang += ROT_DEG[i];
			end else begin
				xv -= dx; yv += dy; ang -= ROT_DEG[i];
			end
		end
		mag = xv;
		return ang;
	endfunction

	// Round half up to the output grid and clamp to +-lim_deg degrees.
	function automatic longint round_angle(input longint acc, input longint lim_deg);
		longint v, lim;
		lim = lim_deg << act_pkg::ANGLE_FRACTION_BITS;
		v   = (acc + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	// Expected roll and pitch for one sample.
	function automatic tilt_t tilt_angles(input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		longint ax, ay, az, mag_yz, spare, nx_gain, roll_acc, pitch_acc;
		tilt_t  r;
		ax = x;
		ay = y;
		az = z;
		roll_acc  = cordic_atan2(az * COUNT_GRID, ay * COUNT_GRID, mag_yz);
		nx_gain   = ((-ax) * COUNT_GRID * GAIN_Q30 + (longint'(1) << 29)) >>> 30;
		pitch_acc = cordic_atan2(mag_yz, nx_gain, spare);
		r.roll    = act_pkg::ROLL_W'(round_angle(roll_acc, 180));
		r.pitch   = act_pkg::PITCH_W'(round_angle(pitch_acc, 90));
		return r;
	endfunction

	// Result checker first, then record the prediction for a sample beat
	// taken at this edge.
	always @(posedge clk) begin
		if (done) begin
			if (pending_tilt.size() == 0) begin
				$display("%0t: result with no sample pending: roll %0d pitch %0d",
					$time, roll_angle, pitch_angle);
				err_count++;
			end else begin
				want = pending_tilt.pop_front();
				if (roll_angle !== want.roll) begin
					$display("%0t: roll_angle expected %0d actual %0d",
						$time, want.roll, roll_angle);
					err_count++;
				end
				if (pitch_angle !== want.pitch) begin
					$display("%0t: pitch_angle expected %0d actual %0d",
						$time, want.pitch, pitch_angle);
					err_count++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_tilt.push_back(tilt_angles(accel_x, accel_y, accel_z));
	end

	// Send one sample beat after a random idle gap and wait for its acceptance.
	task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [15:0] rand_word();
		return 16'($urandom);
	endfunction

	// Uniform value in [-lim, lim].
	function automatic logic signed [15:0] rand_near_zero(input int lim);
		return 16'(int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	// One of the axis extremes, zero, unit values, a small value near zero or a random word.
	function automatic logic signed [15:0] rand_landmark();
		case ($urandom_range(0, 6))
			0: return 16'sd0;
			1: return 16'sd1;
			2: return -16'sd1;
			3: return 16'sd32767;
			4: return -16'sd32768;
			5: return rand_near_zero(3);
			default: return rand_word();
		endcase
	endfunction

	task automatic reset_dut();
		arst_n  = 1'b0;
		start   = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Field extremes, quadrant boundaries and zero operands.
	task automatic test_corner_samples();
		send_sample(0, 0, 0);
		send_sample(-32768, 0, 0);
		send_sample(32767, 0, 0);
		send_sample(0, 0, 32767);
		send_sample(0, 0, -32768);
		send_sample(0, 32767, 0);
		send_sample(0, -32768, 0);
		send_sample(100, 0, -1);
		send_sample(-100, 0, -32768);
		send_sample(0, 1, -32768);
		send_sample(0, -1, -32768);
		send_sample(32767, 32767, 32767);
		send_sample(-32768, -32768, -32768);
		send_sample(-32768, 32767, -32768);
		send_sample(32767, -32768, 32767);
		send_sample(-32768, 1, 0);
		send_sample(32767, 0, 1);
		send_sample(1, 1, 1);
		send_sample(-1, -1, -1);
		send_sample(0, -16384, -16384);
		send_sample(0, 16384, -16384);
		send_sample(5000, 0, 16384);
	endtask

	// Full-range random samples.
	task automatic test_uniform_random(input int n);
		repeat (n) send_sample(rand_word(), rand_word(), rand_word());
	endtask

	// Short vectors, where rounding of the gain product and the shifts matter.
	task automatic test_small_vectors(input int n);
		repeat (n) send_sample(rand_near_zero(40), rand_near_zero(40), rand_near_zero(40));
	endtask

	// Samples near the axes and the left half plane boundary.
	task automatic test_axis_aligned(input int n);
		repeat (n) send_sample(rand_landmark(), rand_landmark(), rand_landmark());
	endtask

	// Back-to-back beats with no idle cycles between them.
	task automatic test_back_to_back(input int n);
		max_gap = 0;
		repeat (n) send_sample(rand_word(), rand_landmark(), rand_word());
		max_gap = 4;
	endtask

	// Wait for every pending result, then let the pipeline run empty.
	task automatic drain_results();
		int n;
		start <= 1'b0;
		for (n = 0; n < 4 * PIPE_LAT && pending_tilt.size() != 0; n++)
			@(posedge clk);
		if (pending_tilt.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_tilt.size());
			err_count += pending_tilt.size();
		end
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin
		reset_dut();
		test_corner_samples();
		test_uniform_random(300);
		test_small_vectors(120);
		test_axis_aligned(150);
		test_back_to_back(110);
		drain_results();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#200000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/act_pkg.sv
rtl/act_cordic.sv
rtl/accel_tilt_angles.sv
sim/tb_accel_tilt_angles.sv
